### hdl/object_collision_projection_coprocessor_top_macros.svh
// Assertion macros for the coprocessor top level.
`ifndef OBJECT_COLLISION_PROJECTION_COPROCESSOR_TOP_MACROS_SVH
`define OBJECT_COLLISION_PROJECTION_COPROCESSOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define OCP_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("ocp check failed");
`define OCP_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("ocp check failed");
`else
`define OCP_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define OCP_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

### hdl/ocp_pkg.sv
// Shared types and constants of the collision and projection coprocessor.
package ocp_pkg;
	localparam int RamBytes   = 2048;
	localparam int MaxObjects = 64;
	localparam int AW         = $clog2(RamBytes);
	localparam int EntryBytes = 14;
	localparam int BoxEnd     = EntryBytes * MaxObjects + 2;
	localparam int CW         = $clog2(MaxObjects + 1);

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_CTRL  = 2'd2;

	localparam logic [7:0]  SHARE_ALL    = 8'h0c;
	localparam logic [15:0] NEAR_DEFAULT = 16'h6400;

	typedef enum logic [4:0] {
		S_IDLE, S_KIND, S_BOXHDR, S_ENT, S_ENTRD, S_CMP, S_CMP2, S_CMP3, S_BOXWR,
		S_PHDR, S_PWORD, S_DIV, S_PWR, S_CLR, S_DONE
	} state_t;

	// Requests from the sequencer to the divider.
	typedef struct packed {
		logic        start;
		logic [23:0] num;
		logic [15:0] den;
	} div_req_t;
endpackage

### hdl/object_collision_projection_coprocessor_top.sv
// Top level: bus port, shared RAM, job sequencer and divider.
// Usage: drive opcode/address/data with start high while busy is low; that
// beat is accepted. Each beat gives one result on read_data, window_hit and
// irq_pulse, marked by done for exactly one cycle.
// Opcode 0 reads, 1 writes the shared RAM (only with the window open), 2
// writes the control byte, 3 does nothing.
// A read, write or control write without a start edge is latched, its RAM
// read is registered and done follows with the result; busy stays high
// until done, so such beats do not overlap. A start edge runs a job first:
// the box test reads the header and walks 63 entries, cutting a skipped
// entry short; projection divides each word and then clears the RAM tail
// one byte a cycle. Job time is set by the one-byte RAM port and the
// bit-serial divider.
// Reset clears the control state; the RAM is then swept to zero one byte a
// cycle with busy high. The receiver cannot stall: results are shown once
// and taken.
`include "object_collision_projection_coprocessor_top_macros.svh"
module object_collision_projection_coprocessor_top import ocp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    opcode,
	input  logic [10:0]   address,
	input  logic [7:0]    data,
	output logic          done,
	output logic [7:0]    read_data,
	output logic          window_hit,
	output logic          irq_pulse
);
	logic [7:0] mem [RamBytes];
	logic [7:0] rdat_q;

	state_t state_q, state_d;
	logic [1:0]    op_q;
	logic [AW-1:0] adr_q;
	logic [7:0]    dat_q;
	logic [1:0]    bank_q;
	logic          flag_q;
	logic          prev_q;
	logic          irq_q;
	logic          pend_q;
	logic          init_q;
	logic [AW:0]   ptr_q;
	logic [3:0]    idx_q;
	logic [7:0]    hi_q;
	logic [15:0]   aw_q [6];
	logic [15:0]   bw_q [6];
	logic [7:0]    sel_q;
	logic          ovl_q;
	logic [CW-1:0] cnt_q;
	logic [15:0]   near_q;
	logic [AW:0]   pend_end_q;
	logic [23:0]   quo_q;

	// Memory port controls
	logic          we;
	logic [AW-1:0] wa, ra;
	logic [7:0]    wd;

	div_req_t   dreq;
	logic       ddone;
	logic [23:0] dquot;

	ocp_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quot(dquot));

	logic open_w;
	assign open_w = bank_q == 2'd2 && flag_q;
	assign busy   = state_q != S_IDLE || init_q || pend_q;

	// Read address: the beat's address (job kind byte for a control beat),
	// else the byte pointer, offset by the entry byte during the entry walk.
	assign ra = (state_q == S_IDLE && pend_q) ? ((op_q == OP_CTRL) ? AW'(2) : adr_q)
		: (state_q == S_ENTRD) ? ptr_q[AW-1:0] + {{(AW-4){1'b0}}, idx_q}
		: ptr_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rdat_q <= mem[ra];
	end

	// Comparisons of one axis, selected by idx_q (0,1,2 for x,z,y).
	logic [16:0] dd, ss;
	logic [15:0] a0, a1, b0, b1;
	logic [15:0] bh_eff;
	assign bh_eff = (bw_q[1] == 16'h58 && bw_q[3] == 16'h04 && bw_q[5] == 16'h10
		&& bw_q[4] == 16'h30) ? bw_q[4] : bw_q[5];
	always_comb begin
		case (idx_q[1:0])
			2'd0: begin a0 = aw_q[0]; a1 = aw_q[1]; b0 = bw_q[0]; b1 = bw_q[1]; end
			2'd1: begin a0 = aw_q[2]; a1 = aw_q[3]; b0 = bw_q[2]; b1 = bw_q[3]; end
			default: begin a0 = aw_q[4]; a1 = aw_q[5]; b0 = bw_q[4]; b1 = bw_q[5]; end
		endcase
		if (idx_q[1:0] == 2'd2) b1 = bh_eff;
		dd = (a0 > b0) ? {1'b0, a0 - b0} : {1'b0, b0 - a0};
		ss = {1'b0, a1} + {1'b0, b1};
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (pend_q && op_q == OP_CTRL && dat_q[6] && !prev_q)
				state_d = S_KIND;
			S_KIND:   state_d = (rdat_q == 8'd1) ? S_BOXHDR : (rdat_q == 8'd0) ? S_DONE : S_PHDR;
			S_BOXHDR: if (ptr_q == (AW+1)'(15)) state_d = S_ENT;
			S_ENT:    state_d = (ptr_q >= (AW+1)'(BoxEnd)) ? S_DONE : S_ENTRD;
			S_ENTRD:  if (rdat_q == 8'd0 && sel_q != SHARE_ALL && idx_q == 4'd1)
					state_d = S_ENT;
				else if (idx_q == 4'd13) state_d = S_CMP;
			S_CMP:    state_d = S_CMP2;
			S_CMP2:   state_d = S_CMP3;
			S_CMP3:   state_d = S_BOXWR;
			S_BOXWR:  state_d = S_ENT;
			S_PHDR:   if (ptr_q == (AW+1)'(4)) state_d = S_PWORD;
			S_PWORD:  if (ptr_q >= pend_end_q) state_d = S_CLR;
				else if (idx_q == 4'd2) state_d = S_DIV;
			S_DIV:    if (ddone) state_d = S_PWR;
			S_PWR:    if (idx_q == 4'd1) state_d = S_PWORD;
			S_CLR:    if (ptr_q == (AW+1)'(RamBytes)) state_d = S_DONE;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Outputs: memory write and divider request.
	always_comb begin
		we = 1'b0;
		wa = ptr_q[AW-1:0];
		wd = 8'd0;
		dreq.start = 1'b0;
		dreq.num = {hi_q, rdat_q, 8'd0};
		dreq.den = near_q;
		if (init_q) begin
			we = 1'b1;
		end else if (pend_q && state_q == S_IDLE && op_q == OP_WRITE && open_w) begin
			we = 1'b1; wa = adr_q; wd = dat_q;
		end
		case (state_q)
			S_BOXWR: begin
				we = 1'b1;
				wa = ptr_q[AW-1:0] + AW'(13);
				wd = ovl_q ? 8'd0 : 8'd1;
			end
			S_CMP3: if (ovl_q && dd < ss) begin we = 1'b1; wa = AW'(15); end
			S_PWORD: dreq.start = idx_q == 4'd2 && ptr_q < pend_end_q;
			S_PWR: begin
				we = 1'b1;
				wa = ptr_q[AW-1:0] + {{(AW-1){1'b0}}, idx_q[0]};
				wd = idx_q[0] ? quo_q[7:0] : quo_q[15:8];
			end
			S_CLR: we = ptr_q < (AW+1)'(RamBytes);
			default: ;
		endcase
	end

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			init_q  <= 1'b1;
			ptr_q   <= '0;
			pend_q  <= 1'b0;
			done    <= 1'b0;
			bank_q  <= '0;
			flag_q  <= 1'b0;
			prev_q  <= 1'b1;
			irq_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			done    <= 1'b0;
			if (init_q) begin
				ptr_q <= ptr_q + 1'b1;
				if (ptr_q == (AW+1)'(RamBytes - 1)) begin
					init_q <= 1'b0;
					ptr_q  <= '0;
				end
			end else if (state_q == S_IDLE && !pend_q) begin
				if (start) pend_q <= 1'b1;
			end else if (state_q == S_IDLE && pend_q) begin
				// Address for the read just issued; finish non-job beats.
				if (op_q == OP_CTRL) begin
					bank_q <= dat_q[5:4];
					flag_q <= dat_q[7];
					prev_q <= dat_q[6];
				end
				if (state_d == S_KIND) begin
					ptr_q <= (AW+1)'(2);
					irq_q <= 1'b1;
				end else begin
					pend_q <= 1'b0;
					done   <= 1'b1;
					irq_q  <= 1'b0;
				end
			end else begin
				case (state_q)
					S_KIND: begin
						ptr_q <= (rdat_q == 8'd1) ? (AW+1)'(1) : '0;
						idx_q <= '0;
					end
					S_BOXHDR: begin
						// Bytes 1..14: selector then six words.
						if (ptr_q == (AW+1)'(2)) sel_q <= rdat_q;
						if (ptr_q >= (AW+1)'(4)) begin
							if (!ptr_q[0]) hi_q <= rdat_q;
							else aw_q[3'((ptr_q[3:0] - 4'd5) >> 1)] <= {hi_q, rdat_q};
						end
						ptr_q <= ptr_q + 1'b1;
						if (ptr_q == (AW+1)'(15)) ptr_q <= (AW+1)'(16);
					end
					S_ENT: begin idx_q <= '0; ovl_q <= 1'b1; end
					S_ENTRD: begin
						// rdat_q holds byte idx_q-1 of the entry.
						if (idx_q >= 4'd2) begin
							if (idx_q[0]) bw_q[3'((idx_q - 4'd3) >> 1)] <= {hi_q, rdat_q};
							else hi_q <= rdat_q;
						end
						idx_q <= idx_q + 4'd1;
						if (rdat_q == 8'd0 && sel_q != SHARE_ALL && idx_q == 4'd1)
							ptr_q <= ptr_q + (AW+1)'(EntryBytes);
						if (idx_q == 4'd13) idx_q <= '0;
					end
					S_CMP, S_CMP2, S_CMP3: begin
						if (!(dd < ss)) ovl_q <= 1'b0;
						idx_q <= idx_q + 4'd1;
					end
					S_BOXWR: ptr_q <= ptr_q + (AW+1)'(EntryBytes);
					S_PHDR: begin
						if (ptr_q == (AW+1)'(1)) hi_q <= rdat_q;
						if (ptr_q == (AW+1)'(2)) begin
							cnt_q <= ({hi_q, rdat_q} > 16'(MaxObjects)) ? CW'(MaxObjects)
								: CW'({hi_q, rdat_q});
						end
						if (ptr_q == (AW+1)'(3)) hi_q <= rdat_q;
						if (ptr_q == (AW+1)'(4)) begin
							near_q <= ({hi_q, rdat_q} == 16'd0) ? NEAR_DEFAULT : {hi_q, rdat_q};
							pend_end_q <= (AW+1)'({cnt_q, 1'b0}) + (AW+1)'(4);
							idx_q <= '0;
						end
						if (ptr_q == (AW+1)'(0)) ptr_q <= (AW+1)'(1);
						else if (ptr_q != (AW+1)'(4)) ptr_q <= ptr_q + 1'b1;
					end
					S_PWORD: begin
						// Read high then low byte of the word at ptr_q.
						idx_q <= idx_q + 4'd1;
						if (idx_q == 4'd0 && ptr_q < pend_end_q) ptr_q <= ptr_q + 1'b1;
						if (idx_q == 4'd1) hi_q <= rdat_q;
						if (idx_q == 4'd2) begin
							aw_q[0] <= {hi_q, rdat_q};
							ptr_q <= ptr_q - 1'b1;
							idx_q <= '0;
						end
					end
					S_DIV: if (ddone) begin quo_q <= dquot; idx_q <= '0; end
					S_PWR: begin
						idx_q <= idx_q + 4'd1;
						if (idx_q == 4'd1) begin
							ptr_q <= ptr_q + (AW+1)'(2);
							idx_q <= '0;
						end
					end
					S_CLR: ptr_q <= ptr_q + 1'b1;
					S_DONE: begin pend_q <= 1'b0; done <= 1'b1; end
					default: ;
				endcase
			end
		end
	end

	// Latch the accepted beat.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && !pend_q && !init_q && start) begin
			op_q  <= opcode;
			adr_q <= address;
			dat_q <= data;
		end
	end

	// Result outputs: read byte comes straight from the RAM output register.
	assign read_data  = (done && op_q == OP_READ && open_w) ? rdat_q : 8'd0;
	assign window_hit = bank_q == 2'd2;
	assign irq_pulse  = done && irq_q;

	`OCP_ASSERT_IMP(a_done_one, clk, arst_n, done, !$past(done))
	`OCP_ASSERT_NEXT(a_irq_ctrl, clk, arst_n, irq_pulse, !done)
	`OCP_ASSERT_IMP(a_init_busy, clk, arst_n, init_q, busy)
endmodule

### hdl/ocp_div.sv
// Restoring divider, one quotient bit per cycle.
module ocp_div import ocp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	output logic        done,
	output logic [23:0] quot
);
	logic [23:0] rem_q;
	logic [23:0] quo_q;
	logic [15:0] den_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic [24:0] trial;

	// Shift in the next numerator bit and test against the divisor.
	assign trial = {rem_q, quo_q[23]} - {9'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			run_q <= 1'b1;
			cnt_q <= 5'd24;
		end else if (run_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (run_q) begin
			if (!trial[24]) rem_q <= trial[23:0];
			else rem_q <= {rem_q[22:0], quo_q[23]};
			quo_q <= {quo_q[22:0], ~trial[24]};
		end
	end

	assign done = run_q && cnt_q == 5'd1;
	assign quot = {quo_q[22:0], ~trial[24]};
endmodule
